// ----- rtl/w2c_pkg.sv -----
package w2c_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned PROD_WIDTH  = COORD_WIDTH + 16;
  localparam int unsigned SUM_WIDTH   = COORD_WIDTH + 17;
  localparam int unsigned WIDE_WIDTH  = COORD_WIDTH + 3;
  localparam int unsigned ROT_FRAC    = 14;
  localparam int unsigned CFG_DW      = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int unsigned CFG_AW      = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
  typedef logic signed [15:0]            trig_t;

  localparam logic [CFG_AW-1:0] REG_CAM_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CAM_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CAM_Z = 3'd2;
  localparam logic [CFG_AW-1:0] REG_YAW   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PITCH = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ROLL  = 3'd5;

  // sine 0, cosine 1.0 in Q2.14
  localparam logic [31:0] TRIG_RESET = 32'h0000_4000;

  localparam sum_t ROUND_HALF = sum_t'(1) <<< (ROT_FRAC - 1);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic coord_t sat_coord(input wide_t v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WIDE_WIDTH-1:COORD_WIDTH-1];
    hi_zeros = ~|v[WIDE_WIDTH-1:COORD_WIDTH-1];
    if (hi_ones || hi_zeros) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[WIDE_WIDTH-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

// ----- rtl/w2c_if.sv -----
interface w2c_in_if import w2c_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t world_x;
  coord_t world_y;
  coord_t world_z;

  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

interface w2c_out_if import w2c_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t cam_x;
  coord_t cam_y;
  coord_t cam_z;

  modport source (output valid, output cam_x, output cam_y, output cam_z, input ready);
  modport sink   (input valid, input cam_x, input cam_y, input cam_z, output ready);
endinterface

// ----- rtl/world_to_camera_transform_core.sv -----
// World-to-camera vertex transform.
// vtx_in_i carries one world-space vertex (Q16.16) per beat; vtx_out_o carries
// the camera-space vertex (Q16.16, saturated), one beat per input beat, in order.
// The camera position is subtracted, then the vertex is rotated about Y, X and Z
// using the sine/cosine pairs in the config registers (Q2.14, sine in 31:16).
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0..2 camera x/y/z,
// 3 yaw, 4 pitch, 5 roll); other indexes are ignored. Write only while idle.
// Stages: one subtract stage, then a multiply stage and a sum/round stage for
// each of the three rotations.
// Throughput: one vertex per cycle unless the output stalls; every stage holds 4
// multipliers at most. The last rotation's register is the output register.
// Stall: the whole pipeline freezes while the output holds a beat that is not
// taken; vtx_in_i.ready is low exactly then, so nothing is dropped or repeated.
// Reset: all stage valids clear, camera position goes to 0 and every rotation
// to sine 0, cosine 1.0.
module world_to_camera_transform_core import w2c_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  w2c_in_if.sink            vtx_in_i,
  w2c_out_if.source         vtx_out_o
);

  coord_t      cam_x_q, cam_y_q, cam_z_q;
  logic [31:0] yaw_q, pitch_q, roll_q;

  logic        en;
  logic        sub_valid_q;
  coord_t      x0_q, y0_q, z0_q;
  logic signed [COORD_WIDTH:0] dx, dy, dz;

  logic        rot_y_valid, rot_x_valid, rot_z_valid;
  coord_t      z1, x1, y0_d;
  coord_t      y1, z2, x1_d;
  coord_t      x2, y2, z2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      yaw_q   <= TRIG_RESET;
      pitch_q <= TRIG_RESET;
      roll_q  <= TRIG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAM_X: cam_x_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CAM_Y: cam_y_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CAM_Z: cam_z_q <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_YAW:   yaw_q   <= cfg_wdata_i[31:0];
        REG_PITCH: pitch_q <= cfg_wdata_i[31:0];
        REG_ROLL:  roll_q  <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign en             = !rot_z_valid || vtx_out_o.ready;
  assign vtx_in_i.ready = en;

  always_comb begin
    dx = (COORD_WIDTH+1)'(vtx_in_i.world_x) - (COORD_WIDTH+1)'(cam_x_q);
    dy = (COORD_WIDTH+1)'(vtx_in_i.world_y) - (COORD_WIDTH+1)'(cam_y_q);
    dz = (COORD_WIDTH+1)'(vtx_in_i.world_z) - (COORD_WIDTH+1)'(cam_z_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_valid_q <= 1'b0;
    end else if (en) begin
      sub_valid_q <= vtx_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= sat_coord(wide_t'(dx));
      y0_q <= sat_coord(wide_t'(dy));
      z0_q <= sat_coord(wide_t'(dz));
    end
  end

  // yaw: z1 = z0*c - x0*s, x1 = x0*c + z0*s
  w2c_rot u_rot_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (sub_valid_q),
    .u_i       (z0_q),
    .v_i       (x0_q),
    .pass_i    (y0_q),
    .sin_cos_i (yaw_q),
    .valid_o   (rot_y_valid),
    .p_o       (z1),
    .q_o       (x1),
    .pass_o    (y0_d)
  );

  // pitch: y1 = y0*c - z1*s, z2 = z1*c + y0*s
  w2c_rot u_rot_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (rot_y_valid),
    .u_i       (y0_d),
    .v_i       (z1),
    .pass_i    (x1),
    .sin_cos_i (pitch_q),
    .valid_o   (rot_x_valid),
    .p_o       (y1),
    .q_o       (z2),
    .pass_o    (x1_d)
  );

  // roll: x2 = x1*c - y1*s, y2 = y1*c + x1*s
  w2c_rot u_rot_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (rot_x_valid),
    .u_i       (x1_d),
    .v_i       (y1),
    .pass_i    (z2),
    .sin_cos_i (roll_q),
    .valid_o   (rot_z_valid),
    .p_o       (x2),
    .q_o       (y2),
    .pass_o    (z2_d)
  );

  assign vtx_out_o.valid = rot_z_valid;
  assign vtx_out_o.cam_x = x2;
  assign vtx_out_o.cam_y = y2;
  assign vtx_out_o.cam_z = z2_d;

endmodule

// ----- rtl/w2c_rot.sv -----
// One plane rotation, two stages:
//   p = u*c - v*s,  q = v*c + u*s  (Q2.14 coefficients, round half up, saturate)
// A third coordinate rides along untouched.
module w2c_rot import w2c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  coord_t      u_i,
  input  coord_t      v_i,
  input  coord_t      pass_i,
  input  logic [31:0] sin_cos_i,
  output logic        valid_o,
  output coord_t      p_o,
  output coord_t      q_o,
  output coord_t      pass_o
);

  trig_t  sin_w;
  trig_t  cos_w;

  logic   mul_valid_q;
  prod_t  uc_q, vs_q, vc_q, us_q;
  coord_t mul_pass_q;

  logic   out_valid_q;
  coord_t p_q, q_q, pass_q;

  sum_t   p_sum, q_sum;
  coord_t p_d, q_d;

  assign sin_w = sin_cos_i[31:16];
  assign cos_w = sin_cos_i[15:0];

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uc_q       <= prod_t'(u_i) * prod_t'(cos_w);
      vs_q       <= prod_t'(v_i) * prod_t'(sin_w);
      vc_q       <= prod_t'(v_i) * prod_t'(cos_w);
      us_q       <= prod_t'(u_i) * prod_t'(sin_w);
      mul_pass_q <= pass_i;
    end
  end

  // combine, round, saturate
  always_comb begin
    p_sum = sum_t'(uc_q) - sum_t'(vs_q) + ROUND_HALF;
    q_sum = sum_t'(vc_q) + sum_t'(us_q) + ROUND_HALF;
    p_d   = sat_coord(p_sum[SUM_WIDTH-1:ROT_FRAC]);
    q_d   = sat_coord(q_sum[SUM_WIDTH-1:ROT_FRAC]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      q_q    <= q_d;
      pass_q <= mul_pass_q;
    end
  end

  assign valid_o = out_valid_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
  assign pass_o  = pass_q;

endmodule

// ----- rtl/w2c_checker.sv -----
module w2c_checker import w2c_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input coord_t cam_x_i,
  input coord_t cam_y_i,
  input coord_t cam_z_i
);

  logic drain;
  assign drain = out_ready_i && !in_valid_i;

  // pipeline only stalls on a held output beat
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with a free output");

  // drained cycles, one for each pipeline register, empty the pipeline
  a_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(drain, 1) && $past(drain, 2) && $past(drain, 3) && $past(drain, 4) &&
     $past(drain, 5) && $past(drain, 6) && $past(drain, 7)) |-> !out_valid_i)
    else $error("output beat without a matching input beat");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(cam_x_i) && $stable(cam_y_i) && $stable(cam_z_i)))
    else $error("output beat changed while stalled");

endmodule

bind world_to_camera_transform_core w2c_checker u_w2c_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vtx_in_i.valid),
  .in_ready_i  (vtx_in_i.ready),
  .out_valid_i (vtx_out_o.valid),
  .out_ready_i (vtx_out_o.ready),
  .cam_x_i     (vtx_out_o.cam_x),
  .cam_y_i     (vtx_out_o.cam_y),
  .cam_z_i     (vtx_out_o.cam_z)
);
